// File: rtl/checkerboard_fill_interpolation_defines.svh
// Assertion macros used by the RTL.
`ifndef CHECKERBOARD_FILL_INTERPOLATION_DEFINES_SVH
`define CHECKERBOARD_FILL_INTERPOLATION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CBFI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CBFI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/cbfi_pkg.sv
package cbfi_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int POS_W   = 9;
  localparam int COORD_W = POS_W + 1;
  localparam int DIM_W   = 13;
  localparam int CFG_W   = 10;
  localparam int SUM_W   = CHAN_W + 2;
  localparam int CNT_W   = 3;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(512);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam int RECIP_3     = 683;
  localparam int RECIP_SHIFT = 11;
  localparam int PROD_W      = SUM_W + RECIP_SHIFT;

  typedef struct packed {
    logic             clear;
    logic             add;
    logic [CNT_W-1:0] divisor;
  } acc_ctrl_t;

  function automatic logic [CHAN_W-1:0] div_count(input logic [SUM_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] q;
    prod = PROD_W'(s) * PROD_W'(RECIP_3);
    unique case (n)
      CNT_W'(4): q = s[SUM_W-1:2];
      CNT_W'(3): q = prod[RECIP_SHIFT +: CHAN_W];
      CNT_W'(2): q = s[CHAN_W:1];
      default:   q = s[CHAN_W-1:0];
    endcase
    return q;
  endfunction

endpackage

// File: rtl/cbfi_store.sv
module cbfi_store #(
  parameter int DEPTH = cbfi_pkg::MAX_WIDTH_DEF * cbfi_pkg::MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cbfi_pkg::PIX_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [cbfi_pkg::PIX_W-1:0] rdata
);

  logic [cbfi_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/cbfi_avg.sv
module cbfi_avg (
  input  logic                       clk,
  input  cbfi_pkg::acc_ctrl_t        ctrl,
  input  logic [cbfi_pkg::PIX_W-1:0] sample,
  output logic [cbfi_pkg::PIX_W-1:0] result
);

  localparam int CW = cbfi_pkg::CHAN_W;
  localparam int SW = cbfi_pkg::SUM_W;

  logic [SW-1:0] sum_r;
  logic [SW-1:0] sum_g;
  logic [SW-1:0] sum_b;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (ctrl.add) begin
      sum_r <= sum_r + SW'(sample[2*CW +: CW]);
      sum_g <= sum_g + SW'(sample[CW +: CW]);
      sum_b <= sum_b + SW'(sample[0 +: CW]);
    end
  end

  assign result = {cbfi_pkg::div_count(sum_r, ctrl.divisor),
                   cbfi_pkg::div_count(sum_g, ctrl.divisor),
                   cbfi_pkg::div_count(sum_b, ctrl.divisor)};

endmodule

// File: rtl/checkerboard_fill_interpolation.sv
// Checkerboard fill interpolation. Writes (opcode 0) leave busy low, so a write can follow
// every cycle while no read is in progress; a write to a position whose column and row
// differ in parity, or that lies outside the store, is dropped. A read of a known position
// returns its colour with done high via FETCH and DRAIN; a read of a filled position fetches
// its neighbours through the single read port of the frame store, one neighbour per cycle,
// into a shared per-channel accumulator, divided in FINISH. busy stays high until done; done
// lasts one cycle and the receiver cannot stall it. width_in_use and height_in_use are clamped
// to 2..MAX_WIDTH and 2..MAX_HEIGHT; the user must write them only while idle (not enforced).
`include "checkerboard_fill_interpolation_defines.svh"

module checkerboard_fill_interpolation #(
  parameter int MAX_WIDTH  = cbfi_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbfi_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        opcode,
  input  logic [cbfi_pkg::POS_W-1:0]  col,
  input  logic [cbfi_pkg::POS_W-1:0]  row,
  input  logic [cbfi_pkg::CHAN_W-1:0] red_in,
  input  logic [cbfi_pkg::CHAN_W-1:0] green_in,
  input  logic [cbfi_pkg::CHAN_W-1:0] blue_in,
  output logic                        done,
  output logic [cbfi_pkg::CHAN_W-1:0] red_out,
  output logic [cbfi_pkg::CHAN_W-1:0] green_out,
  output logic [cbfi_pkg::CHAN_W-1:0] blue_out,
  output logic                        was_filled,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [cbfi_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = cbfi_pkg::CHAN_W;
  localparam int XW    = cbfi_pkg::COORD_W;
  localparam int DW    = cbfi_pkg::DIM_W;
  localparam logic [DW-1:0] MAX_W_D = DW'(MAX_WIDTH);
  localparam logic [DW-1:0] MAX_H_D = DW'(MAX_HEIGHT);
  localparam logic [DW-1:0] MIN_D   = DW'(2);
  localparam logic [cbfi_pkg::CNT_W-1:0] MIN_CNT = cbfi_pkg::CNT_W'(2);

  typedef enum logic [1:0] {IDLE, FETCH, DRAIN, FINISH} state_t;

  function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] c, input logic [XW-1:0] r);
    logic [31:0] full;
    full = 32'(r) * 32'(MAX_WIDTH) + 32'(c);
    return full[AW-1:0];
  endfunction

  function automatic logic in_store(input logic [XW-1:0] c, input logic [XW-1:0] r);
    return (DW'(c) < MAX_W_D) && (DW'(r) < MAX_H_D);
  endfunction

  state_t                     state;
  logic [cbfi_pkg::CFG_W-1:0] width_in_use;
  logic [cbfi_pkg::CFG_W-1:0] height_in_use;
  logic [XW-1:0]              cur_col;
  logic [XW-1:0]              cur_row;
  logic                       fill;
  logic [3:0]                 nb_mask;
  logic [1:0]                 k;
  logic                       take_q;
  logic                       pend;
  logic [cbfi_pkg::CNT_W-1:0] divisor;

  logic [DW-1:0]              w_clamp;
  logic [DW-1:0]              h_clamp;
  logic                       accept;
  logic                       read_start;
  logic                       known_in;
  logic [XW-1:0]              col_x;
  logic [XW-1:0]              row_x;
  logic [3:0]                 nb_mask_next;
  logic [XW-1:0]              n_col;
  logic [XW-1:0]              n_row;
  logic                       n_take;
  logic                       last;
  logic                       mem_we;
  logic [cbfi_pkg::PIX_W-1:0] rdata;
  logic [cbfi_pkg::PIX_W-1:0] avg_result;
  cbfi_pkg::acc_ctrl_t        acc_ctrl;

  always_comb begin
    priority if (DW'(width_in_use) < MIN_D) begin
      w_clamp = MIN_D;
    end else if (DW'(width_in_use) > MAX_W_D) begin
      w_clamp = MAX_W_D;
    end else begin
      w_clamp = DW'(width_in_use);
    end
    priority if (DW'(height_in_use) < MIN_D) begin
      h_clamp = MIN_D;
    end else if (DW'(height_in_use) > MAX_H_D) begin
      h_clamp = MAX_H_D;
    end else begin
      h_clamp = DW'(height_in_use);
    end
  end

  assign busy       = (state != IDLE);
  assign accept     = start && !busy;
  assign read_start = accept && (opcode == cbfi_pkg::OP_READ);
  assign known_in   = (col[0] == row[0]);
  assign col_x      = XW'(col);
  assign row_x      = XW'(row);
  assign mem_we     = accept && (opcode == cbfi_pkg::OP_WRITE) && known_in
                      && in_store(col_x, row_x);

  assign nb_mask_next = {(DW'(row_x) + DW'(1)) < h_clamp,
                         row_x != '0,
                         (DW'(col_x) + DW'(1)) < w_clamp,
                         col_x != '0};

  always_comb begin
    n_col = cur_col;
    n_row = cur_row;
    if (fill) begin
      unique case (k)
        2'd0:    n_col = cur_col - XW'(1);
        2'd1:    n_col = cur_col + XW'(1);
        2'd2:    n_row = cur_row - XW'(1);
        default: n_row = cur_row + XW'(1);
      endcase
    end
  end

  assign n_take = (fill ? nb_mask[k] : 1'b1) && in_store(n_col, n_row);
  assign last   = fill ? (k == 2'd3) : 1'b1;

  assign acc_ctrl.clear   = accept;
  assign acc_ctrl.add     = pend && take_q;
  assign acc_ctrl.divisor = divisor;

  cbfi_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pix_addr(col_x, row_x)),
    .wdata ({red_in, green_in, blue_in}),
    .re    (state == FETCH),
    .raddr (pix_addr(n_col, n_row)),
    .rdata (rdata)
  );

  cbfi_avg u_avg (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .sample (rdata),
    .result (avg_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= cbfi_pkg::DIM_RESET;
      height_in_use <= cbfi_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cbfi_pkg::REG_WIDTH:  width_in_use  <= cfg_wdata;
        cbfi_pkg::REG_HEIGHT: height_in_use <= cfg_wdata;
        default:              width_in_use  <= width_in_use;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
      k     <= '0;
    end else begin
      pend <= (state == FETCH);
      unique case (state)
        IDLE: begin
          done <= 1'b0;
          if (read_start) begin
            cur_col <= col_x;
            cur_row <= row_x;
            fill    <= !known_in;
            nb_mask <= nb_mask_next;
            divisor <= cbfi_pkg::CNT_W'($countones(nb_mask_next));
            k       <= '0;
            state   <= FETCH;
          end
        end
        FETCH: begin
          done   <= 1'b0;
          take_q <= n_take;
          k      <= k + 2'd1;
          if (last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (fill) begin
            done  <= 1'b0;
            state <= FINISH;
          end else begin
            red_out    <= take_q ? rdata[2*CW +: CW] : '0;
            green_out  <= take_q ? rdata[CW +: CW] : '0;
            blue_out   <= take_q ? rdata[0 +: CW] : '0;
            was_filled <= 1'b0;
            done       <= 1'b1;
            state      <= IDLE;
          end
        end
        default: begin
          red_out    <= avg_result[2*CW +: CW];
          green_out  <= avg_result[CW +: CW];
          blue_out   <= avg_result[0 +: CW];
          was_filled <= 1'b1;
          done       <= 1'b1;
          state      <= IDLE;
        end
      endcase
    end
  end

  `CBFI_ASSERT_NOW(a_done_idle, clk, rst, done, state == IDLE, "result while busy")
  `CBFI_ASSERT_NEXT(a_read_busy, clk, rst, read_start, busy, "read did not start")
  `CBFI_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe too long")
  `CBFI_ASSERT_NOW(a_fill_divisor, clk, rst, state == FINISH, divisor >= MIN_CNT, "low divisor")

endmodule
